// File: hw/rtl/sbcfa_pkg.sv
// Shared types and constants for the sprite blit, clip, flip and alpha unit.
package sbcfa_pkg;

    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned FIFO_DEPTH  = 4;
    localparam int unsigned FIFO_PTR_W  = 2;
    localparam int unsigned FIFO_CNT_W  = 3;

    localparam logic [31:0] ALPHA_MASK = 32'hFF00_0000;

    // Register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_X     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_Y     = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPRITE_W   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPRITE_H   = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FLIP_H     = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FLIP_V     = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TINT_EN    = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_TINT_COLOR = 4'd7;

    typedef struct packed {
        logic [11:0] dest_x;
        logic [11:0] dest_y;
        logic [8:0]  sprite_width;
        logic [8:0]  sprite_height;
        logic        flip_horizontal;
        logic        flip_vertical;
        logic        tint_enable;
        logic [31:0] tint_color;
    } t_cfg;

    typedef struct packed {
        logic [9:0]  x;
        logic [8:0]  y;
        logic [31:0] color;
    } t_pix;

endpackage

// File: hw/rtl/sbcfa_front.sv
// Front end: texel position counters, flip, origin offset, clip and alpha test.
module sbcfa_front #(
    parameter int FB_WIDTH  = 640,
    parameter int FB_HEIGHT = 480
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sbcfa_pkg::t_cfg    i_cfg,
    input  logic               i_accept,
    input  logic [31:0]        i_texel_color,
    output logic               o_wr,
    output sbcfa_pkg::t_pix    o_pix
);
    import sbcfa_pkg::*;

    localparam logic [12:0] FB_W = 13'(FB_WIDTH);
    localparam logic [12:0] FB_H = 13'(FB_HEIGHT);

    logic [7:0]  r_col, n_col;
    logic [7:0]  r_row, n_row;
    logic [7:0]  w_last, h_last;
    logic [9:0]  mx, my;
    logic [13:0] px, py;
    logic        x_in, y_in, opaque;

    // Zero or anything past 256 acts as 256
    assign w_last = i_cfg.sprite_width[8]  || (i_cfg.sprite_width == 9'd0)
                    ? 8'hFF : i_cfg.sprite_width[7:0] - 8'd1;
    assign h_last = i_cfg.sprite_height[8] || (i_cfg.sprite_height == 9'd0)
                    ? 8'hFF : i_cfg.sprite_height[7:0] - 8'd1;

    // Mirrored offset may go negative when the size shrank mid-sprite
    assign mx = i_cfg.flip_horizontal ? {2'b00, w_last} - {2'b00, r_col} : {2'b00, r_col};
    assign my = i_cfg.flip_vertical   ? {2'b00, h_last} - {2'b00, r_row} : {2'b00, r_row};

    assign px = {{2{i_cfg.dest_x[11]}}, i_cfg.dest_x} + {{4{mx[9]}}, mx};
    assign py = {{2{i_cfg.dest_y[11]}}, i_cfg.dest_y} + {{4{my[9]}}, my};

    assign x_in   = !px[13] && (px[12:0] < FB_W);
    assign y_in   = !py[13] && (py[12:0] < FB_H);
    assign opaque = (i_texel_color & ALPHA_MASK) != 32'd0;

    assign o_wr        = i_accept && opaque && x_in && y_in;
    assign o_pix.x     = px[9:0];
    assign o_pix.y     = py[8:0];
    assign o_pix.color = i_texel_color;

    // Advance in raster order; dropped texels still count
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if (r_col >= w_last) begin
                n_col = 8'd0;
                n_row = (r_row >= h_last) ? 8'd0 : r_row + 8'd1;
            end else begin
                n_col = r_col + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 8'd0;
            r_row <= 8'd0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// File: hw/rtl/sbcfa_fifo.sv
// Short queue between front end and back end.
module sbcfa_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  sbcfa_pkg::t_pix    i_data,
    input  logic               i_rd,
    output sbcfa_pkg::t_pix    o_data,
    output logic               o_full,
    output logic               o_valid
);
    import sbcfa_pkg::*;

    t_pix                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count, n_count;
    logic                  wr_en, rd_en;

    assign o_full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && o_valid;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !rd_en) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a write");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[FIFO_PTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

// File: hw/rtl/sbcfa_back.sv
// Back end: tint and output register toward the result queue interface.
module sbcfa_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tint_enable,
    input  logic [31:0]        i_tint_color,
    input  logic               i_q_valid,
    input  sbcfa_pkg::t_pix    i_q_data,
    output logic               o_q_rd,
    input  logic               i_pop,
    output logic               o_valid,
    output sbcfa_pkg::t_pix    o_pix
);
    import sbcfa_pkg::*;

    logic r_valid;
    t_pix r_pix;

    // Refill whenever the output slot is empty or being drained
    assign o_q_rd  = i_q_valid && (!r_valid || i_pop);
    assign o_valid = r_valid;
    assign o_pix   = r_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_rd) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_pix.x     <= i_q_data.x;
            r_pix.y     <= i_q_data.y;
            r_pix.color <= i_tint_enable ? (i_q_data.color & i_tint_color)
                                         : i_q_data.color;
        end
    end

endmodule

// File: hw/rtl/sprite_blit_clip_flip_alpha_unit.sv
// Top level of the sprite blitter with clipping, flipping, alpha key and tint.
//
// Usage:
//   Input side is a queue write port: drive i_texel_color with the next
//   sprite texel in source raster order and raise push; a transaction
//   happens on a rising edge with push high and full low.
//   Result side is a queue read port: while empty is low, o_pixel_x,
//   o_pixel_y and o_pixel_color hold the oldest framebuffer write; raise
//   pop to take it. Transparent or off-screen texels produce nothing.
//   Configuration goes through i_cfg_valid / o_cfg_ready with a register
//   index and data; o_cfg_ready is always high. Write only while idle.
// Timing:
//   A kept texel is written into the queue and then moves into the output
//   register, where it shows on the result ports until popped. Throughput
//   is one texel per clock while full is low, set by the combinational
//   front end and a four-entry queue ahead of the output register.
// Reset and stall:
//   Reset clears the position counters, the queue and the output slot and
//   loads register defaults (32 by 32 sprite, tint mask all ones).
//   When the receiver stalls, results pile up in the queue; full rises
//   once it holds four, holding off further texels.
module sprite_blit_clip_flip_alpha_unit #(
    parameter int FB_WIDTH  = 640,
    parameter int FB_HEIGHT = 480
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // texel input
    input  logic                               push,
    output logic                               full,
    input  logic [31:0]                        i_texel_color,
    // pixel output
    output logic                               empty,
    input  logic                               pop,
    output logic [9:0]                         o_pixel_x,
    output logic [8:0]                         o_pixel_y,
    output logic [31:0]                        o_pixel_color,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sbcfa_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [31:0]                        i_cfg_data
);
    import sbcfa_pkg::*;

    t_cfg  r_cfg;
    logic  in_accept;
    logic  front_wr;
    t_pix  front_pix;
    t_pix  q_data;
    logic  q_full, q_valid, q_rd;
    logic  out_valid;
    t_pix  out_pix;

    assign o_cfg_ready = 1'b1;

    // Register file: indexes past the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_x          <= 12'd0;
            r_cfg.dest_y          <= 12'd0;
            r_cfg.sprite_width    <= 9'd32;
            r_cfg.sprite_height   <= 9'd32;
            r_cfg.flip_horizontal <= 1'b0;
            r_cfg.flip_vertical   <= 1'b0;
            r_cfg.tint_enable     <= 1'b0;
            r_cfg.tint_color      <= 32'hFFFF_FFFF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DEST_X:     r_cfg.dest_x          <= i_cfg_data[11:0];
                REG_DEST_Y:     r_cfg.dest_y          <= i_cfg_data[11:0];
                REG_SPRITE_W:   r_cfg.sprite_width    <= i_cfg_data[8:0];
                REG_SPRITE_H:   r_cfg.sprite_height   <= i_cfg_data[8:0];
                REG_FLIP_H:     r_cfg.flip_horizontal <= i_cfg_data[0];
                REG_FLIP_V:     r_cfg.flip_vertical   <= i_cfg_data[0];
                REG_TINT_EN:    r_cfg.tint_enable     <= i_cfg_data[0];
                REG_TINT_COLOR: r_cfg.tint_color      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Take a texel whenever the queue has room, even if it will be dropped
    assign full      = q_full;
    assign in_accept = push && !q_full;

    sbcfa_front #(
        .FB_WIDTH  (FB_WIDTH),
        .FB_HEIGHT (FB_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_accept      (in_accept),
        .i_texel_color (i_texel_color),
        .o_wr          (front_wr),
        .o_pix         (front_pix)
    );

    sbcfa_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_wr),
        .i_data  (front_pix),
        .i_rd    (q_rd),
        .o_data  (q_data),
        .o_full  (q_full),
        .o_valid (q_valid)
    );

    sbcfa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tint_enable (r_cfg.tint_enable),
        .i_tint_color  (r_cfg.tint_color),
        .i_q_valid     (q_valid),
        .i_q_data      (q_data),
        .o_q_rd        (q_rd),
        .i_pop         (pop),
        .o_valid       (out_valid),
        .o_pix         (out_pix)
    );

    // Drive the result ports from the output slot
    assign empty         = !out_valid;
    assign o_pixel_x     = out_pix.x;
    assign o_pixel_y     = out_pix.y;
    assign o_pixel_color = out_pix.color;

endmodule

// File: tb/sv/sprite_blit_clip_flip_alpha_unit_tb.sv
// Self-checking testbench for the sprite blit, clip, flip and alpha unit.
`timescale 1ns / 100ps

module sprite_blit_clip_flip_alpha_unit_tb;
    import sbcfa_pkg::*;

    localparam int FB_W = 640;
    localparam int FB_H = 480;

    // Predicts framebuffer writes from accepted texels and matches them
    // against the pixels that leave the block, oldest first.
    class blit_scoreboard;
        t_cfg     cfg;
        bit [7:0] col_pos;
        bit [7:0] row_pos;
        t_pix     pending_pixels[$];
        int       errors;

        function new();
            cfg.dest_x          = 12'd0;
            cfg.dest_y          = 12'd0;
            cfg.sprite_width    = 9'd32;
            cfg.sprite_height   = 9'd32;
            cfg.flip_horizontal = 1'b0;
            cfg.flip_vertical   = 1'b0;
            cfg.tint_enable     = 1'b0;
            cfg.tint_color      = 32'hFFFF_FFFF;
            col_pos = '0;
            row_pos = '0;
            errors  = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_DEST_X:     cfg.dest_x          = data[11:0];
                REG_DEST_Y:     cfg.dest_y          = data[11:0];
                REG_SPRITE_W:   cfg.sprite_width    = data[8:0];
                REG_SPRITE_H:   cfg.sprite_height   = data[8:0];
                REG_FLIP_H:     cfg.flip_horizontal = data[0];
                REG_FLIP_V:     cfg.flip_vertical   = data[0];
                REG_TINT_EN:    cfg.tint_enable     = data[0];
                REG_TINT_COLOR: cfg.tint_color      = data;
                default: ;
            endcase
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%0t: %s", $time, msg);
        endfunction

        // Sizes of zero or above 256 behave as 256.
        function int eff_size(logic [8:0] reg_val);
            return (reg_val == 9'd0 || reg_val > 9'd256) ? 256 : int'(reg_val);
        endfunction

        function void take_texel(logic [31:0] texel);
            int   w;
            int   h;
            int   mx;
            int   my;
            int   px;
            int   py;
            int   ox;
            int   oy;
            t_pix exp_pix;
            w  = eff_size(cfg.sprite_width);
            h  = eff_size(cfg.sprite_height);
            mx = cfg.flip_horizontal ? (w - 1 - int'(col_pos)) : int'(col_pos);
            my = cfg.flip_vertical ? (h - 1 - int'(row_pos)) : int'(row_pos);
            ox = $signed(cfg.dest_x);
            oy = $signed(cfg.dest_y);
            px = ox + mx;
            py = oy + my;
            if ((texel & ALPHA_MASK) != 32'd0 && px >= 0 && px < FB_W &&
                py >= 0 && py < FB_H) begin
                exp_pix.x     = px[9:0];
                exp_pix.y     = py[8:0];
                exp_pix.color = cfg.tint_enable ? (texel & cfg.tint_color) : texel;
                pending_pixels.push_back(exp_pix);
            end
            // Counters advance even for dropped texels.
            if (int'(col_pos) >= w - 1) begin
                col_pos = '0;
                if (int'(row_pos) >= h - 1)
                    row_pos = '0;
                else
                    row_pos = row_pos + 8'd1;
            end else begin
                col_pos = col_pos + 8'd1;
            end
        endfunction

        function void match_pixel(logic [9:0] x, logic [8:0] y, logic [31:0] color);
            t_pix exp_pix;
            if (pending_pixels.size() == 0) begin
                flag($sformatf("unexpected pixel x=%0d y=%0d color=%08h", x, y, color));
                return;
            end
            exp_pix = pending_pixels.pop_front();
            if (x !== exp_pix.x)
                flag($sformatf("pixel_x expected %0d got %0d", exp_pix.x, x));
            if (y !== exp_pix.y)
                flag($sformatf("pixel_y expected %0d got %0d", exp_pix.y, y));
            if (color !== exp_pix.color)
                flag($sformatf("pixel_color expected %08h got %08h", exp_pix.color, color));
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        function void flush();
            t_pix exp_pix;
            while (pending_pixels.size() != 0) begin
                exp_pix = pending_pixels.pop_front();
                flag($sformatf("missing pixel x=%0d y=%0d color=%08h",
                               exp_pix.x, exp_pix.y, exp_pix.color));
            end
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   push          = 1'b0;
    logic                   full;
    logic [31:0]            i_texel_color = '0;
    logic                   empty;
    logic                   pop           = 1'b0;
    logic [9:0]             o_pixel_x;
    logic [8:0]             o_pixel_y;
    logic [31:0]            o_pixel_color;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [31:0]            i_cfg_data    = '0;

    blit_scoreboard sb = new();

    // Idle control: percentage chance of a burst before each transaction,
    // and a flag that turns all idling off for the closing stretch.
    int push_gap_pct = 0;
    int pop_gap_pct  = 0;
    int pop_hold     = 0;
    bit calm         = 1'b0;

    sprite_blit_clip_flip_alpha_unit #(
        .FB_WIDTH  (FB_W),
        .FB_HEIGHT (FB_H)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_texel_color (i_texel_color),
        .empty         (empty),
        .pop           (pop),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: stall in random bursts, otherwise keep pop high.
    always @(negedge i_clk) begin
        if (pop_hold > 0) begin
            pop_hold--;
            pop = 1'b0;
        end else if (!calm && $urandom_range(99) < pop_gap_pct) begin
            pop_hold = $urandom_range(18, 0);
            pop = 1'b0;
        end else begin
            pop = 1'b1;
        end
    end

    // Check every result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.match_pixel(o_pixel_x, o_pixel_y, o_pixel_color);
    end

    // Write one register; hold valid high for the caller to drop.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready)
                break;
        end
        sb.set_reg(idx, data);
    endtask

    // Load the whole register set, then release the channel.
    task automatic program_sprite(input logic [11:0] dx, input logic [11:0] dy,
                                  input logic [8:0] w, input logic [8:0] h,
                                  input bit fh, input bit fv, input bit te,
                                  input logic [31:0] tc);
        write_reg(REG_DEST_X, {20'd0, dx});
        write_reg(REG_DEST_Y, {20'd0, dy});
        write_reg(REG_SPRITE_W, {23'd0, w});
        write_reg(REG_SPRITE_H, {23'd0, h});
        write_reg(REG_FLIP_H, {31'd0, fh});
        write_reg(REG_FLIP_V, {31'd0, fv});
        write_reg(REG_TINT_EN, {31'd0, te});
        write_reg(REG_TINT_COLOR, tc);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Present one texel, optionally after an idle burst, and wait for the
    // transaction. Push stays high afterwards so texels can go back to back.
    task automatic feed_texel(input logic [31:0] texel);
        int gap;
        if (!calm && $urandom_range(99) < push_gap_pct) begin
            gap = $urandom_range(19, 1);
            @(negedge i_clk);
            push = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push          = 1'b1;
        i_texel_color = texel;
        forever begin
            @(posedge i_clk);
            if (!full)
                break;
        end
        sb.take_texel(texel);
    endtask

    // Drop push, let every predicted pixel drain, then give the pipeline
    // time to retire texels that produce nothing.
    task automatic settle();
        @(negedge i_clk);
        push = 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Mostly small sprites so rows and whole sprites wrap often; now and
    // then the full 256 and the out-of-range encodings.
    function automatic logic [8:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 9'($urandom_range(16, 1));
        else if (r < 85)
            return 9'($urandom_range(64, 17));
        else if (r < 93)
            return 9'd256;
        else if (r < 96)
            return 9'd0;
        return 9'($urandom_range(511, 257));
    endfunction

    // Mostly near the framebuffer so sprites straddle its edges.
    function automatic logic [11:0] pick_origin(input int span);
        if ($urandom_range(99) < 75)
            return 12'($urandom_range(span + 40, 0) - 40);
        return 12'($urandom_range(4095, 0));
    endfunction

    function automatic logic [31:0] pick_texel();
        logic [31:0] t;
        t = $urandom;
        if ($urandom_range(99) < 20)
            t[31:24] = 8'h00;
        else if (t[31:24] == 8'h00)
            t[31:24] = 8'h01;
        return t;
    endfunction

    function automatic int pick_gap_pct();
        case ($urandom_range(2))
            0: return 0;
            1: return 10;
            default: return 40;
        endcase
    endfunction

    initial begin
        logic [31:0] opening [6] = '{32'h00FF_FFFF, 32'hFFFF_FFFF, 32'h0100_0000,
                                     32'h0000_0000, 32'h8000_0001, 32'h7FFF_FFFE};
        logic [31:0] tint;
        int          sent;
        int          guard;
        int          r;

        // Hold reset, then release it on a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        pop_gap_pct  = 10;
        push_gap_pct = 10;

        // Reset configuration: alpha key at both extremes of the alpha byte.
        foreach (opening[i])
            feed_texel(opening[i]);
        settle();

        // Tiny sprite at the bottom-right corner, both flips and tint.
        // The column counter is beyond the new width, so the first mirrored
        // position lies left of the sprite.
        program_sprite(12'd638, 12'd478, 9'd2, 9'd2, 1'b1, 1'b1, 1'b1, 32'h0F0F_F0F0);
        repeat (6) feed_texel({8'hFF, 24'($urandom)});
        settle();

        // Most negative x, most positive y, size encodings that mean 256:
        // every texel falls off screen.
        program_sprite(12'h800, 12'h7FF, 9'd0, 9'h1FF, 1'b0, 1'b0, 1'b0, 32'h0000_0000);
        repeat (4) feed_texel({8'hFF, 24'($urandom)});
        settle();

        // Clip at the left and top edges with an all-zero tint mask.
        program_sprite(12'hFFF, 12'hFFF, 9'd3, 9'd3, 1'b0, 1'b1, 1'b1, 32'h0000_0000);
        repeat (9) feed_texel({8'h80, 24'($urandom)});
        settle();

        // Random phases: fresh register set, random texels, random idling.
        sent = 0;
        while (sent < 1300) begin
            r = $urandom_range(9);
            tint = (r == 0) ? 32'h0000_0000 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
            program_sprite(pick_origin(FB_W), pick_origin(FB_H), pick_size(), pick_size(),
                           1'($urandom_range(1)), 1'($urandom_range(1)),
                           1'($urandom_range(1)), tint);
            push_gap_pct = pick_gap_pct();
            pop_gap_pct  = pick_gap_pct();
            repeat ($urandom_range(80, 10)) begin
                feed_texel(pick_texel());
                sent++;
                if (sent >= 1150)
                    calm = 1'b1;
            end
            settle();
        end

        // Wait out anything still in flight, then settle the verdict.
        for (guard = 0; sb.pending() != 0 && guard < 2000; guard++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        sb.flush();
        if (sb.errors == 0)
            $display("sprite_blit_clip_flip_alpha_unit_tb: clean");
        else
            $display("sprite_blit_clip_flip_alpha_unit_tb: errors");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #5_000_000;
        $display("sprite_blit_clip_flip_alpha_unit_tb: errors");
        $finish;
    end

endmodule
